### hw/rtl/tsh_pkg.sv
// ----------------------------------------------------------------------------
// tsh_pkg: shared types and constants of the tar stream header parser
// Holds the field widths, the header layout, the byte kind codes and the
// result record that the parser core hands to the top level.
// ----------------------------------------------------------------------------
package tsh_pkg;

   localparam int BLOCK_BYTES  = 512;
   localparam int SIZE_DIGITS  = 12;
   localparam int MAGIC_OFFSET = 257;
   localparam int MAGIC_BYTES  = 6;
   localparam int SIZE_OFFSET  = 124;

   localparam int BYTE_W = 8;
   localparam int POS_W  = $clog2(BLOCK_BYTES);
   localparam int SIZE_W = 36;
   localparam int CPOS_W = SIZE_W + 1;

   typedef enum logic [1:0] {
      KIND_HEADER  = 2'd0,
      KIND_CONTENT = 2'd1,
      KIND_PADDING = 2'd2,
      KIND_DROPPED = 2'd3
   } kind_type;

   typedef struct packed {
      logic [BYTE_W-1:0] byte_out;
      kind_type          byte_kind;
      logic              header_done;
      logic [SIZE_W-1:0] entry_size;
      logic              entry_end;
      logic              bad_magic;
   } result_type;

   function automatic logic [BYTE_W-1:0] magic_char(input logic [2:0] idx);
      logic [BYTE_W-1:0] c;
      case (idx)
         3'd0:    c = 8'h75;
         3'd1:    c = 8'h73;
         3'd2:    c = 8'h74;
         3'd3:    c = 8'h61;
         3'd4:    c = 8'h72;
         3'd5:    c = 8'h20;
         default: c = 8'h20;
      endcase
      return c;
   endfunction

endpackage

### hw/rtl/tsh_parse.sv
// ----------------------------------------------------------------------------
// tsh_parse: framing state and per-beat classification
// Holds the header and content counters, the magic and size parsers and the
// sticky error flag, and labels one archive byte per enabled cycle.
// ----------------------------------------------------------------------------
module tsh_parse
   import tsh_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              step,
   input  logic [BYTE_W-1:0] data_byte,
   output result_type        result
);

   typedef enum logic [1:0] {
      PHASE_SKIP   = 2'd0,
      PHASE_DIGITS = 2'd1,
      PHASE_STOP   = 2'd2
   } phase_type;

   localparam logic [POS_W-1:0]  LAST_POS   = POS_W'(BLOCK_BYTES - 1);
   localparam logic [POS_W-1:0]  MAGIC_LO   = POS_W'(MAGIC_OFFSET);
   localparam logic [POS_W-1:0]  MAGIC_HI   = POS_W'(MAGIC_OFFSET + MAGIC_BYTES);
   localparam logic [POS_W-1:0]  SIZE_LO    = POS_W'(SIZE_OFFSET);
   localparam logic [POS_W-1:0]  SIZE_HI    = POS_W'(SIZE_OFFSET + SIZE_DIGITS);
   localparam logic [CPOS_W-1:0] BLOCK_MASK = CPOS_W'(BLOCK_BYTES - 1);

   logic [POS_W-1:0]  hpos_ff, hpos_in;
   logic              magic_ok_ff, magic_ok_in;
   logic [SIZE_W-1:0] acc_ff, acc_in;
   phase_type         phase_ff, phase_in;
   logic              in_content_ff, in_content_in;
   logic [CPOS_W-1:0] cpos_ff, cpos_in;
   logic [SIZE_W-1:0] elen_ff, elen_in;
   logic [CPOS_W-1:0] plen_ff, plen_in;
   logic              halted_ff, halted_in;

   logic              octal;
   logic [2:0]        digit;
   logic [CPOS_W-1:0] cpos_next;
   logic [CPOS_W-1:0] padded;
   logic [2:0]        magic_idx;

   assign octal     = (data_byte >= 8'h30) && (data_byte <= 8'h37);
   assign digit     = data_byte[2:0];
   assign cpos_next = cpos_ff + CPOS_W'(1);
   assign padded    = ({1'b0, acc_ff} + BLOCK_MASK) & ~BLOCK_MASK;
   assign magic_idx = 3'(hpos_ff - MAGIC_LO);

   always_comb begin
      hpos_in       = hpos_ff;
      magic_ok_in   = magic_ok_ff;
      acc_in        = acc_ff;
      phase_in      = phase_ff;
      in_content_in = in_content_ff;
      cpos_in       = cpos_ff;
      elen_in       = elen_ff;
      plen_in       = plen_ff;
      halted_in     = halted_ff;

      result.byte_out    = data_byte;
      result.byte_kind   = KIND_HEADER;
      result.header_done = 1'b0;
      result.entry_size  = '0;
      result.entry_end   = 1'b0;
      result.bad_magic   = 1'b0;

      if (halted_ff) begin
         result.byte_kind = KIND_DROPPED;
      end else if (in_content_ff) begin
         result.byte_kind = (cpos_ff < {1'b0, elen_ff}) ? KIND_CONTENT : KIND_PADDING;
         cpos_in = cpos_next;
         if (cpos_next >= plen_ff) begin
            result.entry_end = 1'b1;
            in_content_in    = 1'b0;
            cpos_in          = '0;
         end
      end else begin
         if ((hpos_ff >= MAGIC_LO) && (hpos_ff < MAGIC_HI)) begin
            if (data_byte != magic_char(magic_idx)) begin
               magic_ok_in = 1'b0;
            end
         end
         if ((hpos_ff >= SIZE_LO) && (hpos_ff < SIZE_HI)) begin
            case (phase_ff)
               PHASE_SKIP: begin
                  if (octal) begin
                     acc_in   = SIZE_W'(digit);
                     phase_in = PHASE_DIGITS;
                  end else if (data_byte != 8'h20) begin
                     phase_in = PHASE_STOP;
                  end
               end
               PHASE_DIGITS: begin
                  if (octal) begin
                     acc_in = {acc_ff[SIZE_W-4:0], digit};
                  end else begin
                     phase_in = PHASE_STOP;
                  end
               end
               default: begin
                  phase_in = phase_ff;
               end
            endcase
         end
         if (hpos_ff == LAST_POS) begin
            if (!magic_ok_in) begin
               result.bad_magic = 1'b1;
               halted_in        = 1'b1;
            end else begin
               result.header_done = 1'b1;
               result.entry_size  = acc_ff;
               if (acc_ff == '0) begin
                  result.entry_end = 1'b1;
               end else begin
                  in_content_in = 1'b1;
                  cpos_in       = '0;
                  elen_in       = acc_ff;
                  plen_in       = padded;
               end
            end
            hpos_in     = '0;
            magic_ok_in = 1'b1;
            acc_in      = '0;
            phase_in    = PHASE_SKIP;
         end else begin
            hpos_in = hpos_ff + POS_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hpos_ff       <= '0;
         magic_ok_ff   <= 1'b1;
         acc_ff        <= '0;
         phase_ff      <= PHASE_SKIP;
         in_content_ff <= 1'b0;
         cpos_ff       <= '0;
         elen_ff       <= '0;
         plen_ff       <= '0;
         halted_ff     <= 1'b0;
      end else if (step) begin
         hpos_ff       <= hpos_in;
         magic_ok_ff   <= magic_ok_in;
         acc_ff        <= acc_in;
         phase_ff      <= phase_in;
         in_content_ff <= in_content_in;
         cpos_ff       <= cpos_in;
         elen_ff       <= elen_in;
         plen_ff       <= plen_in;
         halted_ff     <= halted_in;
      end
   end

endmodule

### hw/rtl/tar_stream_header_parser.sv
// ----------------------------------------------------------------------------
// tar_stream_header_parser: byte-stream ustar header framer
// Labels every byte of a tar archive as header, content, padding or
// discarded, and reports each parsed header with the entry size from its octal field.
//
// Usage:
//   The req_ channel carries one archive byte per beat; the rsp_ channel
//   returns one labeled beat per input beat, in order.
//   An accepted request beat passes through the input register, then the
//   parser and the result register, before it shows at rsp_valid.
//   Throughput is one beat per cycle while rsp_stall is low, set by the
//   update of the header and content counters in the parser core.
//   When rsp_stall is high, a full result register holds its beat and an
//   empty input register still takes one more beat before req_stall rises.
//   Reset clears the valid flags of both registers and returns the parser to the start of a
//   header with the error flag clear. After a bad magic every later beat
//   is returned as discarded until the next reset.
// ----------------------------------------------------------------------------
module tar_stream_header_parser
   import tsh_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  logic [BYTE_W-1:0] req_data_byte,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output logic [BYTE_W-1:0] rsp_byte_out,
   output logic [1:0]        rsp_byte_kind,
   output logic              rsp_header_done,
   output logic [SIZE_W-1:0] rsp_entry_size,
   output logic              rsp_entry_end,
   output logic              rsp_bad_magic
);

   logic              in_valid_ff;
   logic [BYTE_W-1:0] in_byte_ff;
   logic              out_valid_ff;
   result_type        out_result_ff;
   result_type        result;
   logic              advance;
   logic              load;

   assign advance   = in_valid_ff && (!out_valid_ff || !rsp_stall);
   assign load      = !in_valid_ff || advance;
   assign req_stall = !load;

   tsh_parse u_parse (
      .clock     (clock),
      .reset     (reset),
      .step      (advance),
      .data_byte (in_byte_ff),
      .result    (result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         if (load) begin
            in_valid_ff <= req_valid;
         end
         if (advance) begin
            out_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         in_byte_ff <= req_data_byte;
      end
      if (advance) begin
         out_result_ff <= result;
      end
   end

   assign rsp_valid       = out_valid_ff;
   assign rsp_byte_out    = out_result_ff.byte_out;
   assign rsp_byte_kind   = out_result_ff.byte_kind;
   assign rsp_header_done = out_result_ff.header_done;
   assign rsp_entry_size  = out_result_ff.entry_size;
   assign rsp_entry_end   = out_result_ff.entry_end;
   assign rsp_bad_magic   = out_result_ff.bad_magic;

   a_done_excl : assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !(rsp_header_done && rsp_bad_magic))
      else $error("header_done and bad_magic on the same beat");

   a_flags_header : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_header_done || rsp_bad_magic)) |-> (rsp_byte_kind == KIND_HEADER))
      else $error("header flag on a beat not labeled header");

   a_size_only_done : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_header_done) |-> (rsp_entry_size == '0))
      else $error("entry_size nonzero outside header_done");

   a_stall_holds_input : assert property (@(posedge clock) disable iff (reset)
      (in_valid_ff && out_valid_ff && rsp_stall) |-> req_stall)
      else $error("request taken while both registers are full and stalled");

endmodule
